FILE: src/dlefr_pkg.sv
// Shared codes, types and the CRC byte update for the DLE frame receiver.
`default_nettype none

package dlefr_pkg;

	localparam logic [7:0] DLE_CODE = 8'h10;
	localparam logic [7:0] SYN_CODE = 8'h16;
	localparam logic [7:0] ETX_CODE = 8'h03;

	localparam logic [15:0] CRC_POLY_RESET = 16'h1021;

	// receiver phase codes
	localparam logic [2:0] PH_HUNT_DLE = 3'd0;
	localparam logic [2:0] PH_HUNT_SYN = 3'd1;
	localparam logic [2:0] PH_PAYLOAD  = 3'd2;
	localparam logic [2:0] PH_CRC_HI   = 3'd3;
	localparam logic [2:0] PH_CRC_LO   = 3'd4;

	// result kinds
	localparam logic [2:0] K_DATA     = 3'd0;
	localparam logic [2:0] K_RESTART  = 3'd1;
	localparam logic [2:0] K_GOOD     = 3'd2;
	localparam logic [2:0] K_CRCERR   = 3'd3;
	localparam logic [2:0] K_OVERFLOW = 3'd4;
	localparam logic [2:0] K_ABORT    = 3'd5;

	typedef struct packed {
		logic [2:0]  phase;
		logic        esc;
		logic [15:0] crc;
	} rx_state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_byte;
		logic       last;
	} res_t;

	// MSB-first CRC-16, one byte, unrolled over its eight bits
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] b, input logic [15:0] poly);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ poly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: src/dlefr_ifs.sv
// Valid/ready channel interfaces for received bytes and frame results.
`default_nettype none

interface dlefr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface dlefr_frame_if #(
	parameter int LEN_W = 9
);
	logic             valid;
	logic             ready;
	logic [2:0]       kind;
	logic [7:0]       data_byte;
	logic [LEN_W-1:0] frame_length;
	logic             last;

	modport source (output valid, output kind, output data_byte, output frame_length,
		output last, input ready);
	modport sink (input valid, input kind, input data_byte, input frame_length,
		input last, output ready);
endinterface

`default_nettype wire

FILE: src/dle_frame_receiver_crc16.sv
// Top level of the DLE byte-stuffed frame receiver with CRC-16 check.
`default_nettype none

// Takes one raw serial byte per transaction on rx and returns at most one result per byte
// on frame: an unstuffed data byte, a restart notice, or an end status (good, CRC error,
// overflow at MAX_LEN payload bytes, abort) with last set. A byte is held in the input
// register and its result lands in the output register; the whole per-byte update,
// including the eight-bit CRC step, is combinational, so a byte can be accepted on
// every clock while frame is ready. Bytes that give no result still pass the output
// register slot. crc_polynomial is to be written through cfg_wr_en/cfg_wr_data only
// while idle; the block does not enforce this. It resets to 0x1021. frame_length is
// $clog2(MAX_LEN+1) bits wide; the frame interface must be built with that LEN_W.
module dle_frame_receiver_crc16 #(
	parameter int MAX_LEN = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	dlefr_byte_if.sink          rx,
	dlefr_frame_if.source       frame
);
	import dlefr_pkg::*;

	localparam int LEN_W = $clog2(MAX_LEN + 1);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             valid_s2;
	res_t             res_s2;
	logic [LEN_W-1:0] len_s2;

	rx_state_t        state_q;
	logic [LEN_W-1:0] count_q;
	logic [15:0]      poly_q;

	rx_state_t        nst;
	logic [LEN_W-1:0] ncnt;
	logic             step_emit;
	res_t             step_res;
	logic [LEN_W-1:0] step_len;

	logic advance;
	logic fire_s1;
	logic rx_fire;

	assign advance  = !valid_s2 || frame.ready;
	assign rx.ready = !valid_s1 || advance;
	assign rx_fire  = rx.valid && rx.ready;
	assign fire_s1  = valid_s1 && advance;

	dlefr_step #(
		.MAX_LEN(MAX_LEN)
	) u_step (
		.st   (state_q),
		.cnt  (count_q),
		.b    (byte_s1),
		.poly (poly_q),
		.nst  (nst),
		.ncnt (ncnt),
		.emit (step_emit),
		.res  (step_res),
		.len  (step_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{phase: PH_HUNT_DLE, esc: 1'b0, crc: 16'h0000};
			count_q  <= '0;
			poly_q   <= CRC_POLY_RESET;
		end else begin
			if (rx_fire) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= fire_s1 && step_emit;
			end
			if (fire_s1) begin
				state_q <= nst;
				count_q <= ncnt;
			end
			if (cfg_wr_en) begin
				poly_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire) begin
			byte_s1 <= rx.rx_byte;
		end
		if (fire_s1 && step_emit) begin
			res_s2 <= step_res;
			len_s2 <= step_len;
		end
	end

	assign frame.valid        = valid_s2;
	assign frame.kind         = res_s2.kind;
	assign frame.data_byte    = res_s2.data_byte;
	assign frame.frame_length = len_s2;
	assign frame.last         = res_s2.last;

	// an end status always leaves the receiver hunting with a cleared frame
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && step_emit && step_res.last) |=>
		(state_q.phase == PH_HUNT_DLE && count_q == '0 && !state_q.esc))
		else $error("frame end did not clear receiver state");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LEN_W'(MAX_LEN))
		else $error("byte count beyond length limit");

	a_esc_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.esc |-> (state_q.phase == PH_PAYLOAD))
		else $error("escape pending outside payload");

	// state only moves when the input stage hands a byte on
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> ($stable(state_q) && $stable(count_q)))
		else $error("receiver state changed without a byte");

endmodule

`default_nettype wire

FILE: src/dlefr_step.sv
// Per-byte next-state and result logic: hunt, unstuff, CRC and length checks.
`default_nettype none

module dlefr_step #(
	parameter int MAX_LEN = 256
) (
	input  dlefr_pkg::rx_state_t                 st,
	input  logic [$clog2(MAX_LEN+1)-1:0]         cnt,
	input  logic [7:0]                           b,
	input  logic [15:0]                          poly,
	output dlefr_pkg::rx_state_t                 nst,
	output logic [$clog2(MAX_LEN+1)-1:0]         ncnt,
	output logic                                 emit,
	output dlefr_pkg::res_t                      res,
	output logic [$clog2(MAX_LEN+1)-1:0]         len
);
	import dlefr_pkg::*;

	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN);

	logic [15:0]      crc_next;
	logic [LEN_W-1:0] cnt_inc;
	logic             in_frame;

	assign crc_next = crc16_byte(st.crc, b, poly);
	assign cnt_inc  = cnt + LEN_W'(1);
	assign in_frame = (st.phase == PH_PAYLOAD) || (st.phase == PH_CRC_HI) ||
		(st.phase == PH_CRC_LO);

	always_comb begin
		nst           = st;
		ncnt          = cnt;
		emit          = 1'b0;
		res.kind      = K_DATA;
		res.data_byte = 8'h00;
		res.last      = 1'b0;
		len           = cnt;
		if (in_frame && cnt >= LEN_LIMIT) begin
			emit      = 1'b1;
			res.kind  = K_OVERFLOW;
			res.last  = 1'b1;
			nst       = '{phase: PH_HUNT_DLE, esc: 1'b0, crc: 16'h0000};
			ncnt      = '0;
		end else begin
			unique case (st.phase)
				PH_HUNT_SYN: begin
					if (b == SYN_CODE) begin
						nst  = '{phase: PH_PAYLOAD, esc: 1'b0, crc: 16'h0000};
						ncnt = '0;
					end else begin
						nst.phase = PH_HUNT_DLE;
					end
				end
				PH_PAYLOAD: begin
					if (!st.esc) begin
						if (b == DLE_CODE) begin
							nst.esc = 1'b1;
						end else begin
							nst.crc       = crc_next;
							ncnt          = cnt_inc;
							emit          = 1'b1;
							res.data_byte = b;
							len           = cnt_inc;
						end
					end else begin
						nst.esc = 1'b0;
						case (b)
							DLE_CODE: begin
								nst.crc       = crc_next;
								ncnt          = cnt_inc;
								emit          = 1'b1;
								res.data_byte = b;
								len           = cnt_inc;
							end
							SYN_CODE: begin
								nst.crc  = 16'h0000;
								ncnt     = '0;
								emit     = 1'b1;
								res.kind = K_RESTART;
							end
							ETX_CODE: begin
								nst.phase = PH_CRC_HI;
							end
							default: begin
								emit     = 1'b1;
								res.kind = K_ABORT;
								res.last = 1'b1;
								nst      = '{phase: PH_HUNT_DLE, esc: 1'b0, crc: 16'h0000};
								ncnt     = '0;
							end
						endcase
					end
				end
				PH_CRC_HI: begin
					nst.crc   = crc_next;
					nst.phase = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					emit     = 1'b1;
					res.kind = (crc_next == 16'h0000) ? K_GOOD : K_CRCERR;
					res.last = 1'b1;
					nst      = '{phase: PH_HUNT_DLE, esc: 1'b0, crc: 16'h0000};
					ncnt     = '0;
				end
				default: begin
					// first-DLE hunt; unused codes land here too
					nst.phase = (b == DLE_CODE) ? PH_HUNT_SYN : PH_HUNT_DLE;
					nst.esc   = 1'b0;
					nst.crc   = 16'h0000;
					ncnt      = '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
